@@ sv/tcw_pkg.sv @@
// Package for the text console character writer: screen geometry, control codes,
// cursor and result types. No dependencies.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    // internal cursor widths follow the screen size
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELL_W = (COLUMNS * ROWS > 1) ? $clog2(COLUMNS * ROWS) : 1;

    // fixed widths of the result word fields
    localparam int CODE_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int ADDR_OUT_W = 11;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;

    localparam int TAB_STEP   = 8;
    localparam int TAB_SHIFT  = $clog2(TAB_STEP);

    localparam logic [CODE_W-1:0] CODE_BELL  = 8'd7;
    localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_FF    = 8'd12;
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

    localparam logic [ATTR_W-1:0] COLOR_RESET = 8'd7;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cursor_t;

    // packed from the top down so the first field lands in the highest bits and the last in the lowest
    typedef struct packed {
        logic [ROW_OUT_W-1:0]  cursor_row;
        logic [COL_OUT_W-1:0]  cursor_col;
        logic                  beep;
        logic [ATTR_W-1:0]     cell_attr;
        logic [CODE_W-1:0]     cell_code;
        logic [ADDR_OUT_W-1:0] write_address;
        logic                  write_enable;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ sv/text_console_char_writer_top.sv @@
// Top level of the text console character writer: input word register, cursor
// state, attribute register and result register. Depends on tcw_pkg, tcw_step.
//
// Usage: character bytes arrive on the s_ stream, one per word in s_tdata.
// Each accepted word yields exactly one result word on the m_ stream: the
// screen cell write (enable, linear address, code, attribute), a beep flag
// and the cursor position after the character. The attribute is loaded from
// cfg_wr_data when cfg_wr_en is high; the user must do so only while the
// block is idle, as the block itself does not enforce it.
// An accepted word is held in the input register, then moves to the result
// register, shown on m_tvalid, once the result register is free. Throughput
// is one word per cycle while m_tready stays high: the input register hands
// its word to the result register in the same cycle that it is drained.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready drops until m_tready returns.
// Reset (aresetn low, synchronous) empties both registers, puts the cursor at
// row 0, column 0 and sets the attribute to 7.
`default_nettype none

module text_console_char_writer_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] char_code
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [0] write_enable, [11:1] write_address, [19:12] cell_code,
    // [27:20] cell_attr, [28] beep, [35:29] cursor_col, [40:36] cursor_row
    output logic [tcw_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire logic                         cfg_wr_en,
    input  wire logic [7:0]                   cfg_wr_data
);
    import tcw_pkg::*;

    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic [ATTR_W-1:0] color_reg;
    cursor_t           cursor_reg;
    cursor_t           cursor_next;
    result_t           step_result;
    logic              advance;

    tcw_step u_step (
        .code     (in_code_reg),
        .color    (color_reg),
        .cur      (cursor_reg),
        .cur_next (cursor_next),
        .result   (step_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            color_reg     <= COLOR_RESET;
            cursor_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                cursor_reg    <= cursor_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

endmodule

`default_nettype wire

@@ sv/tcw_step.sv @@
// Per-character cursor update and cell write decode, purely combinational.
// Depends on tcw_pkg.
`default_nettype none

module tcw_step (
    input  wire logic [tcw_pkg::CODE_W-1:0] code,
    input  wire logic [tcw_pkg::ATTR_W-1:0] color,
    input  wire tcw_pkg::cursor_t           cur,
    output tcw_pkg::cursor_t                cur_next,
    output tcw_pkg::result_t                result
);
    import tcw_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    logic [ROW_W-1:0]  row_down;
    logic [COL_W:0]    col_tab;
    logic              we;
    logic [CODE_W-1:0] cc;
    logic              bp;
    cursor_t           wr_pos;
    logic [CELL_W-1:0] addr;

    assign row_down = (cur.row == ROW_LAST) ? cur.row : cur.row + 1'b1;
    // next multiple of the tab step
    assign col_tab  = (((COL_W+1)'(cur.col) >> TAB_SHIFT) + 1'b1) << TAB_SHIFT;

    always_comb begin
        cur_next = cur;
        wr_pos   = cur;
        we       = 1'b0;
        cc       = CODE_SPACE;
        bp       = 1'b0;
        priority if (code >= CODE_SPACE) begin
            we = 1'b1;
            cc = code;
            if (cur.col == COL_LAST) begin
                cur_next.col = '0;
                cur_next.row = row_down;
            end else begin
                cur_next.col = cur.col + 1'b1;
            end
        end else begin
            unique case (code)
                CODE_LF:   cur_next.row = row_down;
                CODE_CR:   cur_next.col = '0;
                CODE_TAB: begin
                    if (col_tab >= (COL_W+1)'(COLUMNS)) begin
                        cur_next.col = '0;
                        cur_next.row = row_down;
                    end else begin
                        cur_next.col = col_tab[COL_W-1:0];
                    end
                end
                CODE_FF: begin
                    cur_next.col = '0;
                    cur_next.row = ROW_LAST;
                end
                CODE_BELL: bp = 1'b1;
                CODE_BS: begin
                    // nothing happens at the origin
                    if (cur.col != '0) begin
                        cur_next.col = cur.col - 1'b1;
                        we           = 1'b1;
                    end else if (cur.row != '0) begin
                        cur_next.row = cur.row - 1'b1;
                        cur_next.col = COL_LAST;
                        we           = 1'b1;
                    end
                    wr_pos = cur_next;
                end
                default: ;
            endcase
        end
    end

    assign addr = CELL_W'(wr_pos.row * CELL_W'(COLUMNS)) + CELL_W'(wr_pos.col);

    always_comb begin
        result.write_enable  = we;
        result.write_address = we ? ADDR_OUT_W'(addr) : '0;
        result.cell_code     = we ? cc : '0;
        result.cell_attr     = we ? color : '0;
        result.beep          = bp;
        result.cursor_col    = COL_OUT_W'(cur_next.col);
        result.cursor_row    = ROW_OUT_W'(cur_next.row);
    end

endmodule

`default_nettype wire

@@ test/text_console_char_writer_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for text_console_char_writer_top: a directed table of characters, then
// random character streams under several attributes, checked against a cursor predictor.
// Depends on tcw_pkg and the text_console_char_writer_top RTL.

module text_console_char_writer_top_tb;
    import tcw_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    want;
    } char_row_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en   = 1'b0;
    logic [7:0]          cfg_wr_data = '0;

    // predictor state
    int         cur_col   = 0;
    int         cur_row   = 0;
    logic [7:0] text_attr = COLOR_RESET;

    result_t   pending_cells[$];
    char_row_t opening_chars[$];
    int        mismatches  = 0;
    int        sent_count  = 0;
    int        taken_count = 0;
    bit        in_burst    = 1'b0;
    bit        out_burst   = 1'b0;

    text_console_char_writer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic int row_below(int r);
        return (r + 1 >= ROWS) ? ROWS - 1 : r + 1;
    endfunction

    function automatic result_t cell_word(logic we, int addr, logic [7:0] code,
                                          logic [7:0] attr, logic bp, int col, int row);
        result_t r;
        r.write_enable  = we;
        r.write_address = ADDR_OUT_W'(addr);
        r.cell_code     = code;
        r.cell_attr     = attr;
        r.beep          = bp;
        r.cursor_col    = COL_OUT_W'(col);
        r.cursor_row    = ROW_OUT_W'(row);
        return r;
    endfunction

    // Moves the predicted cursor for one character and returns the word it yields.
    function automatic result_t advance_cursor(logic [7:0] ch);
        result_t r;
        r = '0;
        if (ch >= CODE_SPACE) begin
            r = cell_word(1'b1, cur_row * COLUMNS + cur_col, ch, text_attr, 1'b0, 0, 0);
            cur_col++;
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row = row_below(cur_row);
            end
        end else begin
            case (ch)
                CODE_LF: cur_row = row_below(cur_row);
                CODE_CR: cur_col = 0;
                CODE_TAB: begin
                    cur_col = (cur_col / TAB_STEP + 1) * TAB_STEP;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row = row_below(cur_row);
                    end
                end
                CODE_FF: begin
                    cur_col = 0;
                    cur_row = ROWS - 1;
                end
                CODE_BELL: r.beep = 1'b1;
                CODE_BS: begin
                    // at the origin there is no previous cell: nothing happens
                    if (cur_col != 0 || cur_row != 0) begin
                        if (cur_col != 0) begin
                            cur_col--;
                        end else begin
                            cur_row--;
                            cur_col = COLUMNS - 1;
                        end
                        r = cell_word(1'b1, cur_row * COLUMNS + cur_col, CODE_SPACE,
                                      text_attr, 1'b0, 0, 0);
                    end
                end
                default: ;
            endcase
        end
        r.cursor_col = COL_OUT_W'(cur_col);
        r.cursor_row = ROW_OUT_W'(cur_row);
        return r;
    endfunction

    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 8'($urandom_range(32, 255));
        if (roll < 63) return CODE_BS;
        if (roll < 71) return CODE_TAB;
        if (roll < 77) return CODE_LF;
        if (roll < 82) return CODE_CR;
        if (roll < 85) return CODE_FF;
        if (roll < 90) return CODE_BELL;
        return 8'($urandom_range(0, 31));
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch on word %0d: expected %0d, got %0d",
                         $time, field, taken_count, want, got);
        end
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_char(logic [7:0] ch, logic typed, result_t want);
        int      gap;
        result_t predicted;
        if (sent_count % 40 == 0) in_burst = ($urandom_range(0, 3) == 0);
        gap = in_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        predicted = advance_cursor(ch);
        pending_cells.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    task automatic set_color(logic [7:0] color);
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        text_attr = color;
    endtask

    initial begin : result_sink
        result_t got;
        result_t want;
        int      stall;
        wait (aresetn === 1'b1);
        forever begin
            if (taken_count % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
            stall = out_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word %h", $time, got);
            end else begin
                want = pending_cells.pop_front();
                check_field("write_enable", want.write_enable, got.write_enable);
                check_field("write_address", want.write_address, got.write_address);
                check_field("cell_code", want.cell_code, got.cell_code);
                check_field("cell_attr", want.cell_attr, got.cell_attr);
                check_field("beep", want.beep, got.beep);
                check_field("cursor_col", want.cursor_col, got.cursor_col);
                check_field("cursor_row", want.cursor_row, got.cursor_row);
            end
            taken_count++;
        end
    end

    initial begin : stimulus
        logic [7:0] color;

        // rows with typed results start from reset, attribute 7
        opening_chars.push_back('{8'h41, 1'b1,
                                  cell_word(1'b1, 0, 8'h41, COLOR_RESET, 1'b0, 1, 0)});
        opening_chars.push_back('{CODE_BS, 1'b1,
                                  cell_word(1'b1, 0, CODE_SPACE, COLOR_RESET, 1'b0, 0, 0)});
        opening_chars.push_back('{CODE_BS, 1'b1,
                                  cell_word(1'b0, 0, 8'h00, 8'h00, 1'b0, 0, 0)});
        opening_chars.push_back('{CODE_BELL, 1'b1,
                                  cell_word(1'b0, 0, 8'h00, 8'h00, 1'b1, 0, 0)});
        opening_chars.push_back('{8'h00, 1'b1, cell_word(1'b0, 0, 8'h00, 8'h00, 1'b0, 0, 0)});
        opening_chars.push_back('{8'hFF, 1'b1,
                                  cell_word(1'b1, 0, 8'hFF, COLOR_RESET, 1'b0, 1, 0)});
        opening_chars.push_back('{CODE_SPACE, 1'b1,
                                  cell_word(1'b1, 1, CODE_SPACE, COLOR_RESET, 1'b0, 2, 0)});
        opening_chars.push_back('{8'h1F, 1'b1, cell_word(1'b0, 0, 8'h00, 8'h00, 1'b0, 2, 0)});
        opening_chars.push_back('{CODE_TAB, 1'b0, '0});
        opening_chars.push_back('{8'h71, 1'b0, '0});
        opening_chars.push_back('{CODE_TAB, 1'b0, '0});
        opening_chars.push_back('{CODE_LF, 1'b0, '0});
        opening_chars.push_back('{CODE_CR, 1'b0, '0});
        opening_chars.push_back('{CODE_FF, 1'b1,
                                  cell_word(1'b0, 0, 8'h00, 8'h00, 1'b0, 0, ROWS - 1)});
        // backspace from column 0 climbs to the end of the row above
        opening_chars.push_back('{CODE_BS, 1'b0, '0});
        opening_chars.push_back('{CODE_LF, 1'b0, '0});
        // printable in the very last cell, cursor clamps on the last row
        opening_chars.push_back('{8'h7E, 1'b0, '0});
        opening_chars.push_back('{CODE_LF, 1'b0, '0});
        opening_chars.push_back('{CODE_BS, 1'b0, '0});
        opening_chars.push_back('{CODE_TAB, 1'b0, '0});
        opening_chars.push_back('{CODE_BS, 1'b0, '0});
        opening_chars.push_back('{8'h4D, 1'b0, '0});
        opening_chars.push_back('{8'h80, 1'b0, '0});
        opening_chars.push_back('{8'h0B, 1'b0, '0});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_chars[i])
            send_char(opening_chars[i].ch, opening_chars[i].typed, opening_chars[i].want);

        for (int phase = 0; phase < 5; phase++) begin
            color = (phase == 0) ? 8'h00 :
                    (phase == 1) ? 8'hFF : 8'($urandom_range(1, 254));
            set_color(color);
            repeat (200) send_char(pick_char(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** text_console_char_writer_top: PASSED **");
        end else begin
            $display("** text_console_char_writer_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("** text_console_char_writer_top: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
sv/tcw_pkg.sv
sv/tcw_step.sv
sv/text_console_char_writer_top.sv
test/text_console_char_writer_top_tb.sv
